// ===== hw/rtl/dmc_pkg.sv =====
// Shared constants and types for the direct-mapped cache tag lookup.
`timescale 1ns / 1ps
`default_nettype none
package dmc_pkg;

	// Address split and storage geometry
	localparam int ADDR_W     = 32;
	localparam int IDX_W      = 12;
	localparam int LINE_COUNT = 1 << IDX_W;
	localparam int TAG_W      = ADDR_W;
	localparam int ENTRY_W    = TAG_W + 1;
	localparam int CNT_W      = 32;

	// Configuration registers
	localparam int OFF_W      = 5;
	localparam int IB_W       = 4;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_OFFSET = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_INDEX_BITS   = 1'b1;

	localparam logic [OFF_W-1:0] OFF_RESET = 5'd0;
	localparam logic [IB_W-1:0]  IB_RESET  = 4'd12;

	// Result beat: hit, hit count, access count, padded to whole bytes
	localparam int OUT_USED_W = 1 + 2 * CNT_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// Controller to datapath
	typedef struct packed {
		logic clear;   // write one invalid entry of the clearing pass
		logic lookup;  // input beat taken, start tag read
		logic commit;  // compare, update line and counters, load result
	} dmc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;  // clearing pass at its last entry
		logic out_free;  // result register can take a new beat
	} dmc_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/direct_mapped_cache_tag_lookup.sv =====
// Flow: an accepted address beat is read from the tag RAM, then compared and committed;
// commit loads the result register and waits while the previous beat is not yet taken.
// A new address is accepted only once the compare and write-back on the same RAM is done.
// Reset: arst_n clears counters, config and control; a clearing pass then invalidates
// every line, with s_axis_tready low (config writes still taken).
`timescale 1ns / 1ps
`default_nettype none
module direct_mapped_cache_tag_lookup
	import dmc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [ADDR_W-1:0]     s_axis_tdata,  // address
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata   // hit, hit_count, access_count, zero pad
);

	dmc_cmd_t cmd;
	dmc_sts_t sts;

	// Controller
	dmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tvalid(s_axis_tvalid),
		.in_tready(s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	dmc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.address   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_tvalid(m_axis_tvalid),
		.out_tready(m_axis_tready),
		.out_tdata (m_axis_tdata)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/dmc_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/dmc_ctrl.sv =====
// Controller state machine: clearing pass, accept, compare and commit.
`timescale 1ns / 1ps
`default_nettype none
module dmc_ctrl
	import dmc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_tvalid,
	output logic          in_tready,
	input  wire dmc_sts_t sts,
	output dmc_cmd_t      cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_CMP   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// Commands
	assign in_tready  = (state_q == S_IDLE);
	assign cmd.clear  = (state_q == S_CLEAR);
	assign cmd.lookup = in_tvalid && in_tready;
	assign cmd.commit = (state_q == S_CMP) && sts.out_free;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (cmd.lookup) state_nxt = S_CMP;
			end
			S_CMP: begin
				if (cmd.commit) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef SYNTHESIS
	a_clear_runs_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && !sts.clr_last) |=> (state_q == S_CLEAR))
		else $error("clearing pass left early");

	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_tvalid && in_tready) |=> (state_q == S_CMP))
		else $error("accepted beat did not reach compare");

	a_commit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> in_tready)
		else $error("no return to idle after commit");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/dmc_dp.sv =====
// Datapath: config registers, address split, tag RAM, counters, result register.
`timescale 1ns / 1ps
`default_nettype none
module dmc_dp
	import dmc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [ADDR_W-1:0]     address,
	input  wire dmc_cmd_t              cmd,
	output dmc_sts_t                   sts,
	output logic                       out_tvalid,
	input  wire logic                  out_tready,
	output logic [OUT_DATA_W-1:0]      out_tdata
);

	localparam logic [IDX_W-1:0] IDX_ONES = {IDX_W{1'b1}};

	logic [OFF_W-1:0]   off_q;
	logic [IB_W-1:0]    ib_q;
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   idx_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [CNT_W-1:0]   hits_q;
	logic [CNT_W-1:0]   acc_q;
	logic               out_valid_q;
	logic               out_hit_q;
	logic [CNT_W-1:0]   out_hits_q;
	logic [CNT_W-1:0]   out_acc_q;

	logic [ADDR_W-1:0]  shifted;
	logic [IB_W-1:0]    ib_eff;
	logic [IDX_W-1:0]   idx_in;
	logic [TAG_W-1:0]   tag_in;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               hit;
	logic [CNT_W-1:0]   hits_nxt;
	logic [CNT_W-1:0]   acc_nxt;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= OFF_RESET;
			ib_q  <= IB_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLOCK_OFFSET: off_q <= cfg_wdata[OFF_W-1:0];
				REG_INDEX_BITS:   ib_q  <= cfg_wdata[IB_W-1:0];
				default:          ;
			endcase
		end
	end

	// Address split: drop offset, index width clamped to IDX_W bits
	assign shifted = address >> off_q;
	assign ib_eff  = (ib_q > IB_W'(IDX_W)) ? IB_W'(IDX_W) : ib_q;
	assign idx_in  = shifted[IDX_W-1:0] & ~(IDX_ONES << ib_eff);
	assign tag_in  = shifted >> ib_eff;

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			idx_s1 <= idx_in;
			tag_s1 <= tag_in;
		end
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_q == IDX_ONES);

	// Tag RAM: entry is {valid, tag}
	assign hit       = ram_rdata[ENTRY_W-1] && (ram_rdata[TAG_W-1:0] == tag_s1);
	assign ram_we    = cmd.clear || (cmd.commit && !hit);
	assign ram_waddr = cmd.clear ? clr_q : idx_s1;
	assign ram_wdata = cmd.clear ? '0 : {1'b1, tag_s1};
	assign ram_raddr = cmd.lookup ? idx_in : idx_s1;

	dmc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(LINE_COUNT)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Saturating counters
	assign hits_nxt = (hits_q == '1) ? hits_q : hits_q + 1'b1;
	assign acc_nxt  = (acc_q == '1) ? acc_q : acc_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			acc_q  <= '0;
		end else if (cmd.commit) begin
			if (hit) hits_q <= hits_nxt;
			acc_q <= acc_nxt;
		end
	end

	// Result register
	assign sts.out_free = !out_valid_q || out_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_hit_q  <= hit;
			out_hits_q <= hit ? hits_nxt : hits_q;
			out_acc_q  <= acc_nxt;
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_acc_q, out_hits_q, out_hit_q};

`ifndef SYNTHESIS
	a_hits_le_acc: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q <= acc_q)
		else $error("hit count above access count");

	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && hit && hits_q != '1) |=> (hits_q == $past(hits_q) + 1'b1))
		else $error("hit not counted");

	a_no_commit_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_tready) |-> !cmd.commit)
		else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire
